FILE: hw/rtl/pos_pkg.sv
// Shared types and constants of the power output sequencer.
package pos_pkg;

  localparam int SETTLE_W = 8;
  localparam int WAIT_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_ACTIVE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_FLOATING     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_ENABLE         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_VALUE          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_PRESENT_EFUSE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_CHARGE_OK     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_STEPS           = 3'd6;

  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_TIMER   = 3'd1,
    ST_PGWAIT  = 3'd2,
    ST_ON      = 3'd3,
    ST_COMMOFF = 3'd4
  } seq_state_t;

  // Filtered pin levels
  typedef struct packed {
    logic present;
    logic charge;
    logic efuse;
  } levels_t;

  // Sequencer controls taken from the configuration registers
  typedef struct packed {
    logic              present_floating;
    logic              force_enable;
    logic [WAIT_W-1:0] wait_steps;
  } seq_cfg_t;

  // Sequencer status handed to the result register
  typedef struct packed {
    logic [2:0] state;
    logic       out_on;
    logic       init;
  } seq_status_t;

endpackage

FILE: hw/rtl/pos_pin_filter.sv
// Two-counter settle filter for one pin level.
module pos_pin_filter
  import pos_pkg::*;
#(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick,
  input  logic                lvl,
  input  logic [SETTLE_W-1:0] settle,
  output logic                level,
  output logic                level_nxt
);

  localparam int LW = (COUNT_WIDTH > SETTLE_W) ? COUNT_WIDTH : SETTLE_W;

  logic [1:0][COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                        level_r;
  logic [COUNT_WIDTH-1:0]      cnt_sel;
  logic [LW-1:0]               cmax, settle_ext, lim;

  assign cmax       = LW'({COUNT_WIDTH{1'b1}});
  assign settle_ext = LW'(settle);
  // clip the settle count to what the counter can hold
  assign lim        = (settle_ext > cmax) ? cmax : settle_ext;
  assign cnt_sel    = cnt_r[lvl];

  always_comb begin
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    if (tick) begin
      if (LW'(cnt_sel) < lim) begin
        cnt_nxt[lvl] = cnt_sel + 1'b1;
      end else if (level_r != lvl) begin
        level_nxt     = lvl;
        cnt_nxt[~lvl] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      level_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

FILE: hw/rtl/pos_seq.sv
// Five-state power output sequencer with step countdown.
module pos_seq
  import pos_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  levels_t     lv,
  input  logic        comms,
  input  seq_cfg_t    cfg,
  output seq_status_t status_nxt
);

  seq_state_t        state_r, state_nxt;
  logic              out_on_r, out_on_nxt;
  logic [WAIT_W-1:0] countdown_r, countdown_nxt;
  logic              init;
  logic              link_ok;
  seq_state_t        drop_state;

  assign link_ok    = lv.present & lv.charge;
  assign drop_state = cfg.present_floating ? ST_COMMOFF : ST_OFF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_OFF;
      out_on_r    <= 1'b0;
      countdown_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_on_r    <= out_on_nxt;
      countdown_r <= countdown_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_on_nxt    = out_on_r;
    countdown_nxt = countdown_r;
    init          = 1'b0;
    if (step) begin
      case (state_r)
        ST_TIMER: begin
          if (!link_ok) begin
            state_nxt  = drop_state;
            out_on_nxt = 1'b0;
          end else if (countdown_r != '0) begin
            countdown_nxt = countdown_r - 1'b1;
          end else if (lv.efuse) begin
            state_nxt  = ST_ON;
            out_on_nxt = 1'b1;
          end else begin
            state_nxt  = ST_PGWAIT;
            out_on_nxt = 1'b0;
          end
        end
        ST_PGWAIT: begin
          if (!link_ok) begin
            state_nxt  = drop_state;
            out_on_nxt = 1'b0;
          end else if (lv.efuse) begin
            state_nxt  = ST_ON;
            out_on_nxt = 1'b1;
          end
        end
        ST_ON: begin
          if (!link_ok) begin
            state_nxt  = drop_state;
            out_on_nxt = 1'b0;
          end else if (!lv.efuse) begin
            state_nxt  = ST_PGWAIT;
            out_on_nxt = 1'b0;
          end
        end
        ST_COMMOFF: begin
          if (link_ok && (comms || cfg.force_enable)) begin
            state_nxt     = ST_TIMER;
            out_on_nxt    = 1'b1;
            countdown_nxt = cfg.wait_steps;
            init          = 1'b1;
          end
        end
        default: begin
          state_nxt = ST_OFF;
          if (link_ok) begin
            state_nxt     = ST_TIMER;
            out_on_nxt    = 1'b1;
            countdown_nxt = cfg.wait_steps;
            init          = 1'b1;
          end
        end
      endcase
    end
  end

  assign status_nxt.state  = state_nxt;
  assign status_nxt.out_on = out_on_nxt;
  assign status_nxt.init   = init;

endmodule

FILE: hw/rtl/power_output_sequencer_unit.sv
// Top level of the power output sequencer: pin filters, sequencer, I/O registers.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in_     | input     | in_valid / in_stall    | mode, present/charge_ok/efuse pins, comms
//  out_    | output    | out_valid / out_stall  | seq_state, switch_on, ready_res, ...
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index (3 bits), cfg_data (16 bits)
//
// One transaction per cycle sustained while out_stall is low; each passes through the input
// register, then the filter and sequencer update as it moves into the result register.
// The state update is a single short compare-and-increment pass.
// rst_n is synchronous: counters, filtered levels and the sequencer go to off/zero and
// the configuration registers to their documented defaults. cfg_ready is always high.
// A stalled result holds; the input register keeps accepting until it too is full.
module power_output_sequencer_unit
  import pos_pkg::*;
#(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic                  in_present_pin,
  input  logic                  in_charge_ok_pin,
  input  logic                  in_efuse_good_pin,
  input  logic                  in_comms_detected,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_seq_state,
  output logic                  out_switch_on,
  output logic                  out_ready_res,
  output logic                  out_charger_init,
  output logic                  out_present_level,
  output logic                  out_efuse_level,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic                present_active_high_r;
  logic                present_floating_r;
  logic                force_enable_r;
  logic                force_value_r;
  logic [SETTLE_W-1:0] settle_present_efuse_r;
  logic [SETTLE_W-1:0] settle_charge_ok_r;
  logic [WAIT_W-1:0]   wait_steps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_active_high_r  <= 1'b1;
      present_floating_r     <= 1'b0;
      force_enable_r         <= 1'b0;
      force_value_r          <= 1'b0;
      settle_present_efuse_r <= SETTLE_W'(2);
      settle_charge_ok_r     <= SETTLE_W'(1);
      wait_steps_r           <= WAIT_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRESENT_ACTIVE_HIGH:  present_active_high_r  <= cfg_data[0];
        CFG_PRESENT_FLOATING:     present_floating_r     <= cfg_data[0];
        CFG_FORCE_ENABLE:         force_enable_r         <= cfg_data[0];
        CFG_FORCE_VALUE:          force_value_r          <= cfg_data[0];
        CFG_SETTLE_PRESENT_EFUSE: settle_present_efuse_r <= cfg_data[SETTLE_W-1:0];
        CFG_SETTLE_CHARGE_OK:     settle_charge_ok_r     <= cfg_data[SETTLE_W-1:0];
        CFG_WAIT_STEPS:           wait_steps_r           <= cfg_data[WAIT_W-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // input register
  logic in_vld_r;
  logic mode_r, ppin_r, cpin_r, epin_r, comms_r;
  logic out_vld_r;
  logic adv;      // input register moves into the result register
  logic tick, step;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_r  <= in_mode;
      ppin_r  <= in_present_pin;
      cpin_r  <= in_charge_ok_pin;
      epin_r  <= in_efuse_good_pin;
      comms_r <= in_comms_detected;
    end
  end

  assign tick = adv && !mode_r;
  assign step = adv && mode_r;

  // present level after polarity and debug override
  logic pres_raw;
  assign pres_raw = force_enable_r ? force_value_r : (ppin_r == present_active_high_r);

  levels_t lv, lv_nxt;

  pos_pin_filter #(.COUNT_WIDTH(COUNT_WIDTH)) u_present_filt (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .lvl       (pres_raw),
    .settle    (settle_present_efuse_r),
    .level     (lv.present),
    .level_nxt (lv_nxt.present)
  );

  pos_pin_filter #(.COUNT_WIDTH(COUNT_WIDTH)) u_charge_filt (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .lvl       (cpin_r),
    .settle    (settle_charge_ok_r),
    .level     (lv.charge),
    .level_nxt (lv_nxt.charge)
  );

  pos_pin_filter #(.COUNT_WIDTH(COUNT_WIDTH)) u_efuse_filt (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .lvl       (epin_r),
    .settle    (settle_present_efuse_r),
    .level     (lv.efuse),
    .level_nxt (lv_nxt.efuse)
  );

  seq_cfg_t    seq_cfg;
  seq_status_t seq_st;

  assign seq_cfg.present_floating = present_floating_r;
  assign seq_cfg.force_enable     = force_enable_r;
  assign seq_cfg.wait_steps       = wait_steps_r;

  // levels do not move on a step, so the sequencer reads the current ones
  pos_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .lv         (lv),
    .comms      (comms_r),
    .cfg        (seq_cfg),
    .status_nxt (seq_st)
  );

  // result register
  logic [2:0] res_state_r;
  logic       res_out_on_r, res_ready_r, res_init_r, res_present_r, res_efuse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  // capture the post-update view of the transaction
  always_ff @(posedge clk) begin
    if (adv) begin
      res_state_r   <= seq_st.state;
      res_out_on_r  <= seq_st.out_on;
      res_init_r    <= seq_st.init;
      res_ready_r   <= lv_nxt.charge;
      res_present_r <= lv_nxt.present;
      res_efuse_r   <= lv_nxt.efuse;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_seq_state     = res_state_r;
  assign out_switch_on     = res_out_on_r;
  assign out_ready_res     = res_ready_r;
  assign out_charger_init  = res_init_r;
  assign out_present_level = res_present_r;
  assign out_efuse_level   = res_efuse_r;

endmodule
